/* rtl/csf_pkg.sv */
`default_nettype none

package csf_pkg;

    // Fixed field widths
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = 7;
    localparam int LEN_BITS   = IDX_BITS + 1;
    localparam int COS_BITS   = 16;
    localparam int ACC_BITS   = 48;
    localparam int PROD_BITS  = 2 * VALUE_BITS;

    // Default query store depth
    localparam int MAX_DIM = 128;

    // Function codes
    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_CAND  = 1'b1;

    typedef struct packed {
        logic                          func;
        logic [IDX_BITS-1:0]           elem_index;
        logic signed [VALUE_BITS-1:0]  elem_value;
        logic                          last_elem;
    } csf_in_t;

    typedef struct packed {
        logic                          match;
        logic signed [COS_BITS-1:0]    cosine;
        logic                          identical;
        logic                          degenerate;
    } csf_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_EVAL,
        S_NORM,
        S_ROOT,
        S_DEN,
        S_DIV,
        S_DONE
    } csf_state_t;

endpackage

`default_nettype wire

/* rtl/csf_ram.sv */
`default_nettype none

module csf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port: write, or read with the data registered for the next cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/cosine_similarity_threshold_filter.sv */
`default_nettype none

// Cosine similarity threshold filter.
// Input channel: a word on item is taken at a rising edge with start high and busy low.
//   func = query loads one query element into the query store; func = candidate streams
//   one candidate element against the stored query.
// Result channel: result_strobe is high for exactly one cycle with the result word; the
//   receiver cannot stall it, so it must take the word in that cycle.
// Configuration: cfg_data is written into the cosine threshold (signed Q1.14) when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write only while idle.
// A query element or a non-final candidate element keeps busy high through the multiply
//   and accumulate states, so no further word is taken until that item is through.
// A final candidate element keeps busy high through evaluate, the normalize loop, the
//   shared-step square roots, the denominator product, the restoring divider and done;
//   a zero norm skips from evaluate straight to done.
// The result word appears on the cycle busy drops.
// The query store is a single-port RAM; items are taken one at a time, so a store
//   write never overlaps a read of the same entry.
// Reset clears the threshold, query length and sums and sets the all-equal flag; the query
//   store holds no reset value and must be loaded before use.
module cosine_similarity_threshold_filter #(
    parameter int MAX_DIM = csf_pkg::MAX_DIM
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire csf_pkg::csf_in_t                      item,
    output logic                                       result_strobe,
    output csf_pkg::csf_out_t                          result,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic signed [csf_pkg::COS_BITS-1:0]   cfg_data
);

    localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VB        = csf_pkg::VALUE_BITS;
    localparam int AB        = csf_pkg::ACC_BITS;
    localparam int PB        = csf_pkg::PROD_BITS;
    localparam int LB        = csf_pkg::LEN_BITS;
    localparam int DIV_STEPS = 17;

    localparam logic [AB-1:0]   NORM_HI  = AB'(64'h4000_0000);
    localparam logic [AB-1:0]   NORM_LO  = AB'(64'h1000_0000);
    localparam logic [30:0]     CAP30    = 31'h4000_0000;
    localparam logic [16:0]     COS_ONE  = 17'd16384;
    localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};

    typedef struct packed {
        logic [30:0] n;
        logic [31:0] r;
    } root_t;

    function automatic logic signed [AB-1:0] sat_add(
        input logic signed [AB-1:0] a,
        input logic signed [PB-1:0] b
    );
        logic signed [AB:0] s;
        s = (AB+1)'(a) + (AB+1)'(b);
        if (s[AB] != s[AB-1])
        begin
            return s[AB] ? ACC_MIN : ACC_MAX;
        end
        return s[AB-1:0];
    endfunction

    function automatic root_t root_step(input root_t s, input logic [30:0] b);
        root_t       o;
        logic [31:0] sum;
        sum = s.r + 32'(b);
        if ({1'b0, s.n} >= sum)
        begin
            o.n = s.n - sum[30:0];
            o.r = (s.r >> 1) + 32'(b);
        end
        else
        begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // Control state
    csf_pkg::csf_state_t state_reg, state_next;

    // Architectural state
    logic signed [csf_pkg::COS_BITS-1:0] cos_threshold_reg;
    logic [LB-1:0]                       query_len_reg;
    logic signed [AB-1:0]                query_norm_sq_reg;
    logic signed [AB-1:0]                dot_acc_reg;
    logic signed [AB-1:0]                cand_norm_sq_reg;
    logic                                all_equal_reg;

    // Item and datapath registers
    csf_pkg::csf_in_t     item_reg;
    logic signed [PB-1:0] prod_qv_reg;
    logic signed [PB-1:0] prod_vv_reg;
    logic                 eq_reg;
    logic                 ident_reg;
    logic                 degen_reg;
    logic [AB-1:0]        nq_reg;
    logic [AB-1:0]        nc_reg;
    logic signed [4:0]    kq_reg;
    logic signed [4:0]    kc_reg;
    root_t                rq_reg;
    root_t                rc_reg;
    logic [30:0]          bit_reg;
    logic [30:0]          d_reg;
    logic [29:0]          den_reg;
    logic [29:0]          rem_reg;
    logic [16:0]          num_reg;
    logic [16:0]          quo_reg;
    logic [4:0]           div_cnt_reg;
    logic                 result_strobe_reg;
    csf_pkg::csf_out_t    result_reg;

    // Store port
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [VB-1:0]     ram_rdata;

    logic                 accept;
    logic                 in_range_in;
    logic                 q_ok;
    logic signed [VB-1:0] q_val;
    logic                 norm_done;
    logic signed [5:0]    t_val;
    logic [4:0]           s_val;
    logic [AB-1:0]        mag;
    logic [AB-1:0]        d_shr;
    logic [30:0]          d_val;
    logic [AB-1:0]        shl_lim;
    logic [30:0]          rem2;
    logic [16:0]          cos_mag;
    logic signed [csf_pkg::COS_BITS-1:0] cos_val;
    logic                 last_cand;
    logic                 degen_now;

    assign accept      = start && !busy;
    assign in_range_in = (32'(item.elem_index) < MAX_DIM);
    assign cfg_ready   = 1'b1;
    assign ram_addr    = ADDR_W'(item.elem_index);

    csf_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_DIM)
    ) u_query_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.elem_value),
        .rdata (ram_rdata)
    );

    // Query operand: entries past the query length or the store pair with zero
    assign q_ok  = (32'(item_reg.elem_index) < MAX_DIM) &&
                   (LB'(item_reg.elem_index) < query_len_reg);
    assign q_val = q_ok ? $signed(ram_rdata) : '0;

    assign last_cand = (item_reg.func == csf_pkg::FUNC_CAND) && item_reg.last_elem;
    assign degen_now = (query_norm_sq_reg == '0) || (cand_norm_sq_reg == '0);

    assign norm_done = (nq_reg >= NORM_LO) && (nq_reg < NORM_HI) &&
                       (nc_reg >= NORM_LO) && (nc_reg < NORM_HI);

    // Rescale |dot| by the combined normalize exponent, capped at 2^30
    assign t_val   = 6'(kq_reg) + 6'(kc_reg);
    assign s_val   = 5'(-t_val);
    assign mag     = dot_acc_reg[AB-1] ? AB'(-dot_acc_reg) : AB'(dot_acc_reg);
    assign d_shr   = mag >> t_val[4:0];
    assign shl_lim = AB'(CAP30 >> s_val);

    always_comb
    begin
        if (!t_val[5])
        begin
            d_val = (d_shr > AB'(CAP30)) ? CAP30 : d_shr[30:0];
        end
        else if (mag >= shl_lim)
        begin
            d_val = CAP30;
        end
        else
        begin
            d_val = 31'(mag[30:0] << s_val);
        end
    end

    assign rem2    = {rem_reg, num_reg[16]};
    assign cos_mag = (quo_reg > COS_ONE) ? COS_ONE : quo_reg;
    assign cos_val = dot_acc_reg[AB-1] ? -$signed({1'b0, cos_mag[14:0]})
                                       :  $signed({1'b0, cos_mag[14:0]});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = csf_pkg::S_MUL;
                end
            end
            csf_pkg::S_MUL:  state_next = csf_pkg::S_ACC;
            csf_pkg::S_ACC:  state_next = last_cand ? csf_pkg::S_EVAL : csf_pkg::S_IDLE;
            csf_pkg::S_EVAL: state_next = degen_now ? csf_pkg::S_DONE : csf_pkg::S_NORM;
            csf_pkg::S_NORM:
            begin
                if (norm_done)
                begin
                    state_next = csf_pkg::S_ROOT;
                end
            end
            csf_pkg::S_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = csf_pkg::S_DEN;
                end
            end
            csf_pkg::S_DEN:  state_next = csf_pkg::S_DIV;
            csf_pkg::S_DIV:
            begin
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = csf_pkg::S_DONE;
                end
            end
            csf_pkg::S_DONE: state_next = csf_pkg::S_IDLE;
            default:         state_next = csf_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy   = (state_reg != csf_pkg::S_IDLE);
        ram_en = (state_reg == csf_pkg::S_IDLE) && start && in_range_in;
        ram_we = (item.func == csf_pkg::FUNC_QUERY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= csf_pkg::S_IDLE;
            cos_threshold_reg <= '0;
            query_len_reg     <= '0;
            query_norm_sq_reg <= '0;
            dot_acc_reg       <= '0;
            cand_norm_sq_reg  <= '0;
            all_equal_reg     <= 1'b1;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            result_strobe_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                cos_threshold_reg <= cfg_data;
            end
            if (state_reg == csf_pkg::S_ACC)
            begin
                if (item_reg.func == csf_pkg::FUNC_QUERY)
                begin
                    // Index zero restarts the query norm
                    query_norm_sq_reg <= sat_add(
                        (item_reg.elem_index == '0) ? '0 : query_norm_sq_reg, prod_vv_reg);
                    query_len_reg     <= LB'(item_reg.elem_index) + LB'(1);
                end
                else
                begin
                    // Index zero starts a fresh candidate
                    dot_acc_reg      <= sat_add(
                        (item_reg.elem_index == '0) ? '0 : dot_acc_reg, prod_qv_reg);
                    cand_norm_sq_reg <= sat_add(
                        (item_reg.elem_index == '0) ? '0 : cand_norm_sq_reg, prod_vv_reg);
                    all_equal_reg    <= ((item_reg.elem_index == '0) || all_equal_reg) && eq_reg;
                end
            end
            if (state_reg == csf_pkg::S_DONE)
            begin
                // Drop the candidate sums once the result is out
                result_strobe_reg <= 1'b1;
                dot_acc_reg       <= '0;
                cand_norm_sq_reg  <= '0;
                all_equal_reg     <= 1'b1;
            end
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            csf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= item;
                end
            end
            csf_pkg::S_MUL:
            begin
                prod_qv_reg <= q_val * item_reg.elem_value;
                prod_vv_reg <= item_reg.elem_value * item_reg.elem_value;
                eq_reg      <= q_ok && (q_val == item_reg.elem_value);
            end
            csf_pkg::S_ACC:
            begin
                quo_reg <= '0;
            end
            csf_pkg::S_EVAL:
            begin
                ident_reg <= all_equal_reg &&
                             ((LB'(item_reg.elem_index) + LB'(1)) == query_len_reg);
                degen_reg <= degen_now;
                nq_reg    <= AB'(query_norm_sq_reg);
                nc_reg    <= AB'(cand_norm_sq_reg);
                kq_reg    <= '0;
                kc_reg    <= '0;
            end
            csf_pkg::S_NORM:
            begin
                // Shift each norm by two bits a cycle into [2^28, 2^30)
                if (nq_reg >= NORM_HI)
                begin
                    nq_reg <= nq_reg >> 2;
                    kq_reg <= kq_reg + 5'sd1;
                end
                else if (nq_reg < NORM_LO)
                begin
                    nq_reg <= nq_reg << 2;
                    kq_reg <= kq_reg - 5'sd1;
                end
                if (nc_reg >= NORM_HI)
                begin
                    nc_reg <= nc_reg >> 2;
                    kc_reg <= kc_reg + 5'sd1;
                end
                else if (nc_reg < NORM_LO)
                begin
                    nc_reg <= nc_reg << 2;
                    kc_reg <= kc_reg - 5'sd1;
                end
                rq_reg  <= '{n: nq_reg[30:0], r: '0};
                rc_reg  <= '{n: nc_reg[30:0], r: '0};
                bit_reg <= CAP30;
            end
            csf_pkg::S_ROOT:
            begin
                rq_reg  <= root_step(rq_reg, bit_reg);
                rc_reg  <= root_step(rc_reg, bit_reg);
                bit_reg <= bit_reg >> 2;
                d_reg   <= d_val;
            end
            csf_pkg::S_DEN:
            begin
                den_reg     <= rq_reg.r[14:0] * rc_reg.r[14:0];
                rem_reg     <= 30'(d_reg >> 3);
                num_reg     <= {d_reg[2:0], 14'b0};
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            csf_pkg::S_DIV:
            begin
                // One restoring step per cycle
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= 30'(rem2 - {1'b0, den_reg});
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[29:0];
                    quo_reg <= {quo_reg[15:0], 1'b0};
                end
                num_reg     <= {num_reg[15:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            csf_pkg::S_DONE:
            begin
                result_reg.identical  <= ident_reg;
                result_reg.degenerate <= degen_reg;
                if (degen_reg)
                begin
                    result_reg.cosine <= '0;
                    result_reg.match  <= ident_reg;
                end
                else
                begin
                    result_reg.cosine <= cos_val;
                    result_reg.match  <= (cos_val <= cos_threshold_reg) || ident_reg;
                end
            end
            default:
            begin
                quo_reg <= '0;
            end
        endcase
    end

    assign result_strobe = result_strobe_reg;
    assign result        = result_reg;

    // Results never come back to back
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result strobe held for two cycles");

    // An accepted word always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // Cosine stays within plus or minus one
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.cosine <= 16'sd16384 && result.cosine >= -16'sd16384))
        else $error("cosine out of range");

    // A zero norm reports zero cosine
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.degenerate) |-> (result.cosine == '0))
        else $error("degenerate result with nonzero cosine");

    // An identical candidate always matches
    a_ident_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.identical) |-> result.match)
        else $error("identical candidate did not match");

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Hold off longer than the slowest final candidate element keeps the block busy
    localparam int              SETTLE_CYCLES = 64;
    localparam int              FINAL_WAIT    = 5000;
    localparam longint          SUM_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          SUM_MIN       = -SUM_MAX - 1;
    localparam longint unsigned ONE_Q30       = 64'd1 << 30;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    csf_pkg::csf_in_t                     item;
    logic                                 result_strobe;
    csf_pkg::csf_out_t                    result;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic signed [csf_pkg::COS_BITS-1:0]  cfg_data;

    // Shadow state: query store, lengths, running sums and the threshold
    longint                               qry_val [csf_pkg::MAX_DIM];
    bit                                   qry_set [csf_pkg::MAX_DIM];
    int                                   qry_len;
    longint                               qry_energy;
    longint                               dot_sum;
    longint                               cand_energy;
    bit                                   cand_same;
    logic signed [csf_pkg::COS_BITS-1:0]  thresh;

    // Predicted result words, oldest first
    csf_pkg::csf_out_t                    pending_results[$];

    int                                   errors;
    int                                   words_sent;
    int                                   results_seen;
    int                                   cfg_writes;
    int                                   idle_pct;
    bit                                   start_hi;
    logic signed [csf_pkg::VALUE_BITS-1:0] vec_buf [csf_pkg::MAX_DIM];

    cosine_similarity_threshold_filter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- shadow model

    function automatic longint add_sat(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > SUM_MAX)
            s = SUM_MAX;
        if (s < SUM_MIN)
            s = SUM_MIN;
        return s;
    endfunction

    // Bitwise integer square root of a value below 2^30
    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = ONE_Q30;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Shift n by 4^e into [2^28, 2^30) and take the root; e comes back to the caller
    function automatic longint unsigned norm_root(input longint unsigned n, output int e);
        int k;
        k = 0;
        while (n >= ONE_Q30)
        begin
            n >>= 2;
            k++;
        end
        while (n < (ONE_Q30 >> 2))
        begin
            n <<= 2;
            k--;
        end
        e = k;
        return int_root(n);
    endfunction

    function automatic longint cos_q14(input longint dot, input longint unsigned qn,
                                       input longint unsigned cn);
        int              eq;
        int              ec;
        int              t;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned d;
        longint unsigned c;
        den = norm_root(qn, eq);
        den = den * norm_root(cn, ec);
        t = eq + ec;
        mag = dot;
        if (dot < 0)
            mag = -mag;
        // Align |dot| to the scaled roots, capped at 2^30
        if (t >= 0)
        begin
            d = (t >= 63) ? 64'd0 : (mag >> t);
            if (d > ONE_Q30)
                d = ONE_Q30;
        end
        else if (mag >= (ONE_Q30 >> (-t)))
            d = ONE_Q30;
        else
            d = mag << (-t);
        c = d * 64'd16384 / den;
        if (c > 64'd16384)
            c = 64'd16384;
        return (dot < 0) ? -longint'(c) : longint'(c);
    endfunction

    function automatic void clear_cand();
        dot_sum     = 0;
        cand_energy = 0;
        cand_same   = 1'b1;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < csf_pkg::MAX_DIM; i++)
        begin
            qry_val[i] = 0;
            qry_set[i] = 1'b0;
        end
        qry_len    = 0;
        qry_energy = 0;
        thresh     = '0;
        clear_cand();
    endfunction

    // Advance the shadow state by one accepted word; return 1 when a result is due
    function automatic bit predict_word(input csf_pkg::csf_in_t w,
                                        output csf_pkg::csf_out_t r);
        int     idx;
        longint v;
        longint q;
        longint cv;
        bit     ident;
        bit     degen;
        idx = w.elem_index;
        v   = $signed(w.elem_value);
        r   = '0;
        if (w.func == csf_pkg::FUNC_QUERY)
        begin
            if (idx == 0)
                qry_energy = 0;
            qry_val[idx] = v;
            qry_set[idx] = 1'b1;
            qry_energy   = add_sat(qry_energy, v * v);
            qry_len      = idx + 1;
            return 1'b0;
        end
        if (idx == 0)
            clear_cand();
        // Past the query's end the element pairs with zero and breaks equality
        if (idx < qry_len)
            q = qry_val[idx];
        else
        begin
            q = 0;
            cand_same = 1'b0;
        end
        dot_sum     = add_sat(dot_sum, q * v);
        cand_energy = add_sat(cand_energy, v * v);
        if (q != v)
            cand_same = 1'b0;
        if (!w.last_elem)
            return 1'b0;
        ident = cand_same && (idx + 1 == qry_len);
        degen = (qry_energy == 0) || (cand_energy == 0);
        if (degen)
        begin
            cv      = 0;
            r.match = ident;
        end
        else
        begin
            cv      = cos_q14(dot_sum, qry_energy, cand_energy);
            r.match = (cv <= longint'(thresh)) || ident;
        end
        r.cosine     = csf_pkg::COS_BITS'(cv);
        r.identical  = ident;
        r.degenerate = degen;
        clear_cand();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- result checker

    always @(posedge clk)
    begin
        csf_pkg::csf_out_t want;
        if (rst_n && result_strobe)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: match %0b cosine %0d", result.match,
                       $signed(result.cosine));
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.match !== want.match)
                begin
                    $error("match: expected %0b, actual %0b", want.match, result.match);
                    errors++;
                end
                if (result.cosine !== want.cosine)
                begin
                    $error("cosine: expected %0d, actual %0d", $signed(want.cosine),
                           $signed(result.cosine));
                    errors++;
                end
                if (result.identical !== want.identical)
                begin
                    $error("identical: expected %0b, actual %0b", want.identical,
                           result.identical);
                    errors++;
                end
                if (result.degenerate !== want.degenerate)
                begin
                    $error("degenerate: expected %0b, actual %0b", want.degenerate,
                           result.degenerate);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Offer one word, idling first at the current rate; return on the accepting edge
    task automatic send_word(input csf_pkg::csf_in_t w);
        csf_pkg::csf_out_t r;
        int                gap;
        gap = 0;
        while (gap < 400 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (start_hi)
            begin
                start    <= 1'b0;
                start_hi  = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        // Keep start high across back-to-back words: one assignment per edge
        start    <= 1'b1;
        start_hi  = 1'b1;
        item     <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        words_sent++;
        if (predict_word(w, r))
            pending_results.insert(pending_results.size(), r);
    endtask

    // Drop start and hold until every predicted word has come and the block is idle
    task automatic drain_block();
        if (start_hi)
        begin
            start    <= 1'b0;
            start_hi  = 1'b0;
        end
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic signed [csf_pkg::COS_BITS-1:0] th);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= th;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        thresh     = th;
        cfg_writes++;
    endtask

    // Stream vec_buf[0 .. len-1] as one vector; with_last marks the final element
    task automatic stream_vector(input logic func, input int len, input bit with_last);
        csf_pkg::csf_in_t w;
        for (int i = 0; i < len; i++)
        begin
            w.func       = func;
            w.elem_index = csf_pkg::IDX_BITS'(i);
            w.elem_value = vec_buf[i];
            w.last_elem  = with_last && (i == len - 1);
            send_word(w);
        end
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic signed [csf_pkg::VALUE_BITS-1:0] rand_value();
        int s;
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return -16'sd1;
            4, 5:
            begin
                s = int'($urandom_range(8192)) - 4096;
                return csf_pkg::VALUE_BITS'(s);
            end
            default: return csf_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic int rand_len();
        int pick;
        pick = $urandom_range(99);
        if (pick == 0)
            return csf_pkg::MAX_DIM;
        else if (pick < 10)
            return $urandom_range(9, 24);
        else
            return $urandom_range(1, 8);
    endfunction

    function automatic logic signed [csf_pkg::COS_BITS-1:0] rand_threshold();
        case ($urandom_range(5))
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return '0;
            default: return csf_pkg::COS_BITS'(int'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic load_query(input int len);
        bit zeros;
        // A zero query drives following candidates into the zero-norm case until the query is rewritten
        zeros = ($urandom_range(99) < 8);
        for (int i = 0; i < len; i++)
            vec_buf[i] = zeros ? '0 : rand_value();
        stream_vector(csf_pkg::FUNC_QUERY, len, 1'b1);
    endtask

    // One candidate vector, mostly shaped from the current query
    task automatic send_candidate();
        int kind;
        int len;
        int lim;
        bit with_last;
        len = (qry_len > 0) ? qry_len : $urandom_range(1, 8);
        if (len > 24 && $urandom_range(3) != 0)
            len = $urandom_range(1, 8);
        with_last = 1'b1;
        kind = $urandom_range(99);
        for (int i = 0; i < csf_pkg::MAX_DIM; i++)
            vec_buf[i] = (i < qry_len) ? csf_pkg::VALUE_BITS'(qry_val[i]) : rand_value();
        if (kind < 20)
        begin
            // exact copy of the query
        end
        else if (kind < 30)
        begin
            lim = $urandom_range(len - 1);
            vec_buf[lim] = vec_buf[lim] + csf_pkg::VALUE_BITS'($urandom_range(1, 300));
        end
        else if (kind < 40)
        begin
            for (int i = 0; i < len; i++)
                vec_buf[i] = -vec_buf[i];
        end
        else if (kind < 52)
        begin
            for (int i = 0; i < len; i++)
                vec_buf[i] = vec_buf[i] >>> 1;
        end
        else if (kind < 70)
        begin
            for (int i = 0; i < len; i++)
                vec_buf[i] = rand_value();
        end
        else if (kind < 80)
        begin
            // copied prefix with a length that may miss the query's
            lim = (len + 3 > csf_pkg::MAX_DIM) ? csf_pkg::MAX_DIM : len + 3;
            len = $urandom_range(1, lim);
        end
        else if (kind < 85)
        begin
            for (int i = 0; i < len; i++)
                vec_buf[i] = '0;
        end
        else if (kind < 92)
        begin
            // broken vector: no last element, the next index 0 restarts it
            for (int i = 0; i < len; i++)
                vec_buf[i] = rand_value();
            with_last = 1'b0;
        end
        else
        begin
            for (int i = 0; i < len; i++)
                vec_buf[i] = '0;
            vec_buf[$urandom_range(len - 1)] = rand_value();
        end
        stream_vector(csf_pkg::FUNC_CAND, len, with_last);
    endtask

    // A lone word with random content. Query writes stay within the written prefix or the entry
    // just past it, so no entry below the query length is ever left unwritten.
    task automatic send_noise();
        csf_pkg::csf_in_t w;
        int               run;
        run = 0;
        while (run < csf_pkg::MAX_DIM && qry_set[run])
            run++;
        w.func       = 1'($urandom_range(1));
        w.last_elem  = 1'($urandom_range(1));
        w.elem_value = rand_value();
        if (w.func == csf_pkg::FUNC_QUERY)
            w.elem_index = csf_pkg::IDX_BITS'($urandom_range(
                (run < csf_pkg::MAX_DIM) ? run : csf_pkg::MAX_DIM - 1));
        else
            w.elem_index = csf_pkg::IDX_BITS'($urandom_range(csf_pkg::MAX_DIM - 1));
        send_word(w);
    endtask

    task automatic run_mix(input int n_words);
        int stop_at;
        int pick;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                load_query(rand_len());
            else if (pick < 90)
                send_candidate();
            else
                send_noise();
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        csf_pkg::csf_in_t w;
        idle_pct = 0;
        // Query holding both extremes and a unit element
        vec_buf[0] = 16'sh8000;
        vec_buf[1] = 16'sh7FFF;
        vec_buf[2] = 16'sd1;
        stream_vector(csf_pkg::FUNC_QUERY, 3, 1'b1);
        // Exact copy: identical, always a match
        stream_vector(csf_pkg::FUNC_CAND, 3, 1'b1);
        // Opposite direction: cosine near minus one
        vec_buf[0] = 16'sh7FFF;
        vec_buf[1] = 16'sh8000;
        vec_buf[2] = -16'sd1;
        stream_vector(csf_pkg::FUNC_CAND, 3, 1'b1);
        // Zero candidate: zero norm, not identical
        vec_buf[0] = '0;
        vec_buf[1] = '0;
        vec_buf[2] = '0;
        stream_vector(csf_pkg::FUNC_CAND, 3, 1'b1);
        // Copy plus one element beyond the query's end
        vec_buf[0] = 16'sh8000;
        vec_buf[1] = 16'sh7FFF;
        vec_buf[2] = 16'sd1;
        vec_buf[3] = 16'sd7;
        stream_vector(csf_pkg::FUNC_CAND, 4, 1'b1);
        // Copied prefix ending early: length mismatch
        stream_vector(csf_pkg::FUNC_CAND, 2, 1'b1);
        // Lone element at the top index, far past the query
        w.func       = csf_pkg::FUNC_CAND;
        w.elem_index = csf_pkg::IDX_BITS'(csf_pkg::MAX_DIM - 1);
        w.elem_value = 16'sh7FFF;
        w.last_elem  = 1'b1;
        send_word(w);
        // Zero query of length one
        w.func       = csf_pkg::FUNC_QUERY;
        w.elem_index = '0;
        w.elem_value = '0;
        send_word(w);
        // Zero candidate equal to it: zero norm yet identical
        w.func = csf_pkg::FUNC_CAND;
        send_word(w);
        // Nonzero candidate against the zero query
        w.elem_value = 16'sd5;
        send_word(w);
    endtask

    task automatic test_threshold_settings();
        logic signed [csf_pkg::COS_BITS-1:0] sweep [5];
        sweep[0] = 16'sd16384;
        sweep[1] = -16'sd16384;
        sweep[2] = '0;
        sweep[3] = rand_threshold();
        sweep[4] = csf_pkg::COS_BITS'(int'($urandom_range(32768)) - 16384);
        idle_pct = 0;
        for (int s = 0; s < 5; s++)
        begin
            write_threshold(sweep[s]);
            // the full-depth query once, short ones after
            load_query((s == 0) ? csf_pkg::MAX_DIM : $urandom_range(1, 8));
            for (int c = 0; c < 5; c++)
                send_candidate();
        end
    endtask

    task automatic test_random_traffic();
        int rates [3];
        rates[0] = 0;
        rates[1] = 79;
        rates[2] = 8;
        for (int p = 0; p < 3; p++)
        begin
            idle_pct = rates[p];
            write_threshold(rand_threshold());
            run_mix(140);
            // pause the sender until every pending result is in
            drain_block();
            run_mix(140);
        end
    endtask

    // ---------------------------------------------------------------- run

    initial
    begin
        int waited;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        start_hi     = 1'b0;
        idle_pct     = 0;
        errors       = 0;
        words_sent   = 0;
        results_seen = 0;
        cfg_writes   = 0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_settings();
        test_random_traffic();

        // Drop start, let the last results in, then hold past the worst latency
        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d predicted result words never arrived", pending_results.size());
            errors++;
        end

        $display("tb: %0d words in, %0d result words checked, %0d threshold writes",
                 words_sent, results_seen, cfg_writes);
        $display("tb: exercised copies, reversals, zero norms, length mismatches, idle rates");
        if (errors == 0)
        begin
            $display("** cosine_similarity_threshold_filter: PASSED **");
        end
        else
        begin
            $display("** cosine_similarity_threshold_filter: FAILED **");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #20_000_000;
        $display("** cosine_similarity_threshold_filter: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/csf_pkg.sv
rtl/csf_ram.sv
rtl/cosine_similarity_threshold_filter.sv
verif/tb.sv
